// ----- sv/sbrp_pkg.sv -----
// Package for the STUN Binding response parser: constants, types and helpers.
// Used by the interfaces, the datagram walker and the top level.
package sbrp_pkg;

	localparam int unsigned HdrBytes = 20;
	localparam logic [16:0] CountMax = 17'h1FFFF;
	localparam logic [15:0] MsgTypeOk = 16'h0101;
	localparam logic [31:0] Cookie = 32'h2112A442;
	localparam logic [15:0] XmaType = 16'h0020;
	localparam logic [15:0] RequiredLimit = 16'h8000;

	localparam logic [3:0] ErrOk = 4'd0;
	localparam logic [3:0] ErrTrunc = 4'd1;
	localparam logic [3:0] ErrType = 4'd2;
	localparam logic [3:0] ErrCookie = 4'd3;
	localparam logic [3:0] ErrAlign = 4'd4;
	localparam logic [3:0] ErrLength = 4'd5;
	localparam logic [3:0] ErrTxn = 4'd6;
	localparam logic [3:0] ErrMalformed = 4'd7;
	localparam logic [3:0] ErrUnknown = 4'd8;
	localparam logic [3:0] ErrMissing = 4'd9;
	localparam logic [3:0] ErrAddrLen = 4'd10;
	localparam logic [3:0] ErrFamily = 4'd11;

	localparam logic [0:0] RegTxnHigh = 1'd0;
	localparam logic [0:0] RegTxnLow = 1'd1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_datagram;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  error_code;
		logic        is_ipv6;
		logic [15:0] mapped_port;
		logic [63:0] address_high;
		logic [63:0] address_low;
	} out_item_t;

	function automatic logic is_known(input logic [15:0] t);
		case (t)
			16'h0001, 16'h0006, 16'h0008, 16'h0009, 16'h000A, 16'h0014, 16'h0015,
			16'h001C, 16'h001D, 16'h001E, 16'h0020, 16'h8002, 16'h8003, 16'h8022,
			16'h8023, 16'h8028: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic [7:0] txn_byte(input logic [3:0] k, input logic [31:0] hi,
			input logic [63:0] lo);
		logic [95:0] all;
		all = {hi, lo};
		return all[8'(95 - 8 * int'(k)) -: 8];
	endfunction

endpackage

// ----- sv/sbrp_in_if.sv -----
// Input channel: one datagram byte per item. Depends on sbrp_pkg.
interface sbrp_in_if import sbrp_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- sv/sbrp_out_if.sv -----
// Result channel: one parse result per datagram. Depends on sbrp_pkg.
interface sbrp_out_if import sbrp_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- sv/sbrp_walker.sv -----
// Per-byte datagram state: header checks, attribute walk and address decode.
// Depends on sbrp_pkg; produces the result item on the final byte.
module sbrp_walker import sbrp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  in_item_t    item,
	input  logic [31:0] txn_hi,
	input  logic [63:0] txn_lo,
	output out_item_t   result
);
	logic [16:0] byte_count_q;
	logic [31:0] header_word_q;
	logic [15:0] body_length_q;
	logic [3:0]  header_error_q;
	logic [1:0]  ahi_q;
	logic [15:0] attr_type_q;
	logic [15:0] attr_len_q;
	logic [16:0] left_q;
	logic [3:0]  attr_error_q;
	logic        found_q;
	logic [15:0] port_q;
	logic        v6_q;
	logic [63:0] addr_q [2];

	logic [16:0] bc_n;
	logic [31:0] hw_n;
	logic [15:0] bl_n;
	logic [3:0]  he_n;
	logic [1:0]  ahi_n;
	logic [15:0] at_n;
	logic [15:0] al_n;
	logic [16:0] left_n;
	logic [3:0]  ae_n;
	logic        found_n;
	logic [15:0] port_n;
	logic        v6_n;
	logic [63:0] addr_n [2];
	logic [7:0]  b;
	logic [16:0] rel;
	logic [16:0] padded;
	logic [16:0] remaining;
	logic [16:0] vt;
	logic [15:0] alen;
	logic [3:0]  ai;
	logic [7:0]  mask;
	logic [3:0]  err;

	function automatic logic [3:0] note(input logic [3:0] cur, input logic [3:0] code);
		return (cur == ErrOk || code < cur) ? code : cur;
	endfunction

	always_comb begin
		b = item.data_byte;
		bc_n = byte_count_q; hw_n = header_word_q; bl_n = body_length_q;
		he_n = header_error_q; ahi_n = ahi_q; at_n = attr_type_q; al_n = attr_len_q;
		left_n = left_q; ae_n = attr_error_q; found_n = found_q; port_n = port_q;
		v6_n = v6_q; addr_n = addr_q;
		rel = byte_count_q - 17'(HdrBytes);
		padded = '0; remaining = '0; vt = '0; alen = '0; ai = '0; mask = '0;
		if (byte_count_q < 17'(HdrBytes)) begin
			hw_n = {header_word_q[23:0], b};
			if (byte_count_q == 17'd1 && hw_n[15:0] != MsgTypeOk) he_n = note(he_n, ErrType);
			if (byte_count_q == 17'd3) begin
				bl_n = hw_n[15:0];
				if (hw_n[1:0] != 2'b00) he_n = note(he_n, ErrAlign);
			end
			if (byte_count_q == 17'd7 && hw_n != Cookie) he_n = note(he_n, ErrCookie);
			if (byte_count_q >= 17'd8 && b != txn_byte(4'(byte_count_q - 17'd8), txn_hi, txn_lo))
				he_n = note(he_n, ErrTxn);
		end else if (header_error_q == ErrOk && attr_error_q == ErrOk
				&& rel < {1'b0, body_length_q}) begin
			if (left_q == '0) begin
				ahi_n = ahi_q + 2'd1;
				case (ahi_q)
					2'd0: at_n = {b, 8'h00};
					2'd1: at_n = {attr_type_q[15:8], b};
					2'd2: al_n = {b, 8'h00};
					default: begin
						al_n = {attr_len_q[15:8], b};
						padded = ({1'b0, al_n} + 17'd3) & ~17'd3;
						remaining = {1'b0, body_length_q} - (rel + 17'd1);
						if (padded > remaining) ae_n = ErrMalformed;
						else if (attr_type_q == XmaType && !found_q) begin
							if (al_n < 16'd4) ae_n = ErrAddrLen;
							else left_n = padded;
						end else if (!is_known(attr_type_q) && attr_type_q < RequiredLimit) begin
							ae_n = ErrUnknown;
						end else begin
							at_n = '0;
							left_n = padded;
						end
					end
				endcase
			end else begin
				padded = ({1'b0, attr_len_q} + 17'd3) & ~17'd3;
				vt = padded - left_q;
				left_n = left_q - 17'd1;
				if (attr_type_q == XmaType && vt < {1'b0, attr_len_q}) begin
					if (vt == 17'd1) begin
						alen = '0;
						if (b == 8'd1) begin alen = 16'd4; v6_n = 1'b0; end
						else if (b == 8'd2) begin alen = 16'd16; v6_n = 1'b1; end
						else ae_n = ErrFamily;
						if (alen != '0) begin
							if (attr_len_q != alen + 16'd4) ae_n = ErrAddrLen;
							else found_n = 1'b1;
						end
					end else if (vt == 17'd2) begin
						port_n = {b ^ 8'h21, port_q[7:0]};
					end else if (vt == 17'd3) begin
						port_n = {port_q[15:8], b ^ 8'h12};
					end else if (vt >= 17'd4) begin
						ai = 4'(vt - 17'd4);
						mask = (ai < 4'd4) ? Cookie[5'(24 - 8 * int'(ai[1:0])) +: 8]
							: txn_byte(ai - 4'd4, txn_hi, txn_lo);
						addr_n[ai[3]][6'(56 - 8 * int'(ai[2:0])) +: 8] =
							addr_q[ai[3]][6'(56 - 8 * int'(ai[2:0])) +: 8] | (b ^ mask);
					end
				end
			end
		end
		if (byte_count_q < CountMax) bc_n = byte_count_q + 17'd1;

		if (bc_n < 17'(HdrBytes)) err = ErrTrunc;
		else if (he_n != ErrOk && he_n < ErrLength) err = he_n;
		else if (bc_n != 17'(HdrBytes) + {1'b0, bl_n}) err = ErrLength;
		else if (he_n != ErrOk) err = he_n;
		else if (ae_n != ErrOk) err = ae_n;
		else if (!found_n) err = ErrMissing;
		else err = ErrOk;
		result.error_code = err;
		result.is_ipv6 = (err == ErrOk) ? v6_n : 1'b0;
		result.mapped_port = (err == ErrOk) ? port_n : '0;
		result.address_high = (err == ErrOk) ? addr_n[0] : '0;
		result.address_low = (err == ErrOk) ? addr_n[1] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0; header_word_q <= '0; body_length_q <= '0;
			header_error_q <= '0; ahi_q <= '0; attr_type_q <= '0; attr_len_q <= '0;
			left_q <= '0; attr_error_q <= '0; found_q <= 1'b0; port_q <= '0;
			v6_q <= 1'b0; addr_q[0] <= '0; addr_q[1] <= '0;
		end else if (step) begin
			if (item.end_of_datagram) begin
				byte_count_q <= '0; header_word_q <= '0; body_length_q <= '0;
				header_error_q <= '0; ahi_q <= '0; attr_type_q <= '0; attr_len_q <= '0;
				left_q <= '0; attr_error_q <= '0; found_q <= 1'b0; port_q <= '0;
				v6_q <= 1'b0; addr_q[0] <= '0; addr_q[1] <= '0;
			end else begin
				byte_count_q <= bc_n; header_word_q <= hw_n; body_length_q <= bl_n;
				header_error_q <= he_n; ahi_q <= ahi_n; attr_type_q <= at_n;
				attr_len_q <= al_n; left_q <= left_n; attr_error_q <= ae_n;
				found_q <= found_n; port_q <= port_n; v6_q <= v6_n; addr_q <= addr_n;
			end
		end
	end
endmodule

// ----- sv/stun_binding_response_parser.sv -----
// Top level of the STUN Binding success response parser.
// Depends on sbrp_pkg, sbrp_in_if, sbrp_out_if and sbrp_walker.
//
// Usage: datagram bytes arrive on in_ch, one byte per item, the last byte
// flagged by end_of_datagram. Each byte is captured in an input register
// and then processed by the walker, which updates the per-datagram state.
// On the flagged byte one result item leaves on out_ch with the error
// code and, when the code is zero, the decoded family, port and address.
// Every other byte produces no result.
// Throughput is one byte per cycle while no final byte waits on a stalled
// result register. The result item is offered on out_ch from the result
// register and can be taken at the next clock edge.
// The user must write the expected transaction ID through cfg_we,
// cfg_index and cfg_data while the block is idle; it is not enforced.
// Reset clears all datagram state, the ID registers and both valid flags.
// When the receiver stalls, the result register holds its item; the input
// register keeps taking bytes until it holds an item that cannot advance,
// after which in_ch.ready falls.
module stun_binding_response_parser import sbrp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	sbrp_in_if.sink     in_ch,
	sbrp_out_if.source  out_ch,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data
);
	logic        valid_s1;
	in_item_t    item_s1;
	logic        valid_s2;
	out_item_t   result_s2;
	logic [31:0] txn_hi_q;
	logic [63:0] txn_lo_q;
	out_item_t   result;
	logic        adv_s1;
	logic        out_free;

	assign out_free = !valid_s2 || out_ch.ready;
	assign adv_s1 = valid_s1 && (!item_s1.end_of_datagram || out_free);
	assign in_ch.ready = !valid_s1 || adv_s1;
	assign out_ch.valid = valid_s2;
	assign out_ch.data = result_s2;

	sbrp_walker u_walker (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv_s1),
		.item   (item_s1),
		.txn_hi (txn_hi_q),
		.txn_lo (txn_lo_q),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			txn_hi_q <= '0;
			txn_lo_q <= '0;
		end else begin
			if (in_ch.ready) valid_s1 <= in_ch.valid;
			if (out_free) valid_s2 <= adv_s1 && item_s1.end_of_datagram;
			if (cfg_we) begin
				unique case (cfg_index)
					RegTxnHigh: txn_hi_q <= cfg_data[31:0];
					RegTxnLow: txn_lo_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) item_s1 <= in_ch.data;
		if (adv_s1 && item_s1.end_of_datagram) result_s2 <= result;
	end
endmodule

// ----- sv/sbrp_checker.sv -----
// Port-level checks on the STUN Binding response parser, bound to its top.
// Depends on sbrp_pkg.
module sbrp_checker import sbrp_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);
	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.error_code <= ErrFamily) else $error("error code out of range");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.error_code != ErrOk |-> out_data.mapped_port == '0
		&& out_data.address_high == '0 && out_data.address_low == '0 && !out_data.is_ipv6)
		else $error("payload not cleared on error");
	a_v4_low: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.is_ipv6 |-> out_data.address_low == '0)
		else $error("IPv4 result has low address bits");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a waiting result");
endmodule

bind stun_binding_response_parser sbrp_checker u_sbrp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_data  (out_ch.data)
);
